>>> rtl/core/lfe_pkg.sv
// ----------------------------------------------------------------------------
// lfe_pkg
// Shared constants, codes and types of the LED color fade engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lfe_pkg;

	localparam int SLOTS     = 16;
	localparam int TIME_BITS = 32;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int IN_W  = 64;
	localparam int OUT_W = 32;

	localparam logic [1:0] OP_SET   = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_FORCE = 2'd2;

	localparam logic KIND_COLOR  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic [7:0]  src;
		logic [7:0]  dst;
		logic [15:0] t;
		logic [15:0] f;
	} lfe_mix_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SET,
		ST_SCAN,
		ST_HOLD,
		ST_FADE,
		ST_MSTART,
		ST_MWAIT,
		ST_EMIT,
		ST_STAT
	} lfe_state_t;

	typedef enum logic [1:0] {
		MX_IDLE,
		MX_MUL,
		MX_DIV,
		MX_DONE
	} lfe_mix_state_t;

	function automatic logic [7:0] chan_get(input logic [23:0] col, input logic [1:0] ch);
		logic [7:0] v;
		case (ch)
			CH_RED:   v = col[23:16];
			CH_GREEN: v = col[15:8];
			default:  v = col[7:0];
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/lfe_mix.sv
// ----------------------------------------------------------------------------
// lfe_mix
// One color channel step: src + floor((dst - src) * t / f), with t < f.
// One multiply, then an 8-step restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module lfe_mix (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire lfe_pkg::lfe_mix_req_t req,
	output logic                      done,
	output logic [7:0]                result
);
	import lfe_pkg::*;

	lfe_mix_state_t state_q, state_d;
	logic [2:0]  cnt_q;
	logic [7:0]  src_q;
	logic [7:0]  diff_q;
	logic        neg_q;
	logic [15:0] t_q;
	logic [15:0] f_q;
	logic [15:0] rem_q;
	logic [7:0]  quo_q;
	logic [23:0] product;
	logic [16:0] trial;
	logic        qbit;
	logic [7:0]  step;

	assign product = 24'(diff_q) * 24'(t_q);
	assign trial   = {rem_q, quo_q[7]};
	assign qbit    = trial >= 17'(f_q);
	// rounding away from the source, toward the target, on a falling channel
	assign step    = quo_q + 8'(neg_q && (rem_q != 16'd0));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MX_IDLE: if (start) state_d = MX_MUL;
			MX_MUL:  state_d = MX_DIV;
			MX_DIV:  if (cnt_q == 3'd7) state_d = MX_DONE;
			MX_DONE: state_d = MX_IDLE;
			default: state_d = MX_IDLE;
		endcase
	end

	always_comb begin
		done   = (state_q == MX_DONE);
		result = neg_q ? (src_q - step) : (src_q + step);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MX_IDLE;
			cnt_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			if (state_q == MX_DIV) cnt_q <= cnt_q + 3'd1;
			else cnt_q <= 3'd0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MX_IDLE: begin
				if (start) begin
					src_q  <= req.src;
					neg_q  <= req.dst < req.src;
					diff_q <= (req.dst < req.src) ? (req.src - req.dst) : (req.dst - req.src);
					t_q    <= req.t;
					f_q    <= req.f;
				end
			end
			MX_MUL: begin
				rem_q <= product[23:8];
				quo_q <= product[7:0];
			end
			MX_DIV: begin
				rem_q <= qbit ? 16'(trial - 17'(f_q)) : trial[15:0];
				quo_q <= {quo_q[6:0], qbit};
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/led_color_fade_engine.sv
// ----------------------------------------------------------------------------
// led_color_fade_engine
// Per-slot RGB linear crossfade: set, millisecond tick, force-finish.
// ----------------------------------------------------------------------------
// Set word: handled in ST_SET, then ST_EMIT when an output word is produced;
//   the next word is accepted once the engine is back in ST_IDLE.
// Tick/force: per slot ST_SCAN (idle), then ST_HOLD (in hold) or ST_EMIT (forced);
//   a jump to target adds ST_FADE and ST_EMIT, and a fading slot also takes its
//   three channels through the shared 8-step divider.
// One word in flight; not ready until its last output word is registered.
// Reset clears all fades, shown colors (black) and the time counter.
`default_nettype none

module led_color_fade_engine (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// led_slot[3:0], red[11:4], green[19:12], blue[27:20], hold_ms[43:28], fade_ms[59:44]
	input  wire logic [lfe_pkg::IN_W-1:0]  s_tdata,
	// op[1:0]
	input  wire logic [1:0]                s_tuser,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// slot_out[3:0], red_out[11:4], green_out[19:12], blue_out[27:20], any_active[28]
	output logic [lfe_pkg::OUT_W-1:0]      m_tdata,
	// kind[0]
	output logic                           m_tuser,
	output logic                           m_tlast
);
	import lfe_pkg::*;

	lfe_state_t state_q, state_d;

	logic [SLOT_W-1:0]    idx_q;
	logic [1:0]           ch_q;
	logic                 force_q;
	logic                 any_q;
	logic                 emit_last_q;
	logic                 slot_ok_q;
	logic [23:0]          in_col_q;
	logic [15:0]          in_hold_q;
	logic [15:0]          in_fade_q;
	logic [23:0]          col_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] e_q;
	logic [TIME_BITS-1:0] t_q;

	logic                 armed_q  [SLOTS];
	logic [23:0]          shown_q  [SLOTS];
	logic [23:0]          start_q  [SLOTS];
	logic [23:0]          target_q [SLOTS];
	logic [TIME_BITS-1:0] arm_q    [SLOTS];
	logic [15:0]          hold_q   [SLOTS];
	logic [15:0]          fade_q   [SLOTS];

	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;
	logic                 m_tuser_q;
	logic                 m_tlast_q;

	logic                 out_free;
	logic                 out_load;
	logic                 adv;
	logic                 mix_start;
	logic                 mix_done;
	logic [7:0]           mix_res;
	lfe_mix_req_t         mix_req;
	lfe_state_t           adv_state;
	logic                 in_hold;
	logic                 fade_end;
	logic                 timed;

	assign out_free  = !m_tvalid_q || m_tready;
	assign adv_state = (idx_q == SLOT_W'(SLOTS - 1)) ? ST_STAT : ST_SCAN;
	assign in_hold   = e_q <= TIME_BITS'(hold_q[idx_q]);
	assign fade_end  = (fade_q[idx_q] == 16'd0) || (t_q >= TIME_BITS'(fade_q[idx_q]));
	assign timed     = (in_hold_q != 16'd0) || (in_fade_q != 16'd0);

	assign mix_req.src = chan_get(start_q[idx_q], ch_q);
	assign mix_req.dst = chan_get(target_q[idx_q], ch_q);
	assign mix_req.t   = t_q[15:0];
	assign mix_req.f   = fade_q[idx_q];

	lfe_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start),
		.req    (mix_req),
		.done   (mix_done),
		.result (mix_res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						OP_SET:             state_d = ST_SET;
						OP_TICK, OP_FORCE:  state_d = ST_SCAN;
						default:            state_d = ST_IDLE;
					endcase
				end
			end
			ST_SET: begin
				if (!slot_ok_q || timed) state_d = ST_IDLE;
				else state_d = ST_EMIT;
			end
			ST_SCAN: begin
				if (!armed_q[idx_q]) state_d = adv_state;
				else if (force_q) state_d = ST_EMIT;
				else state_d = ST_HOLD;
			end
			ST_HOLD: state_d = in_hold ? adv_state : ST_FADE;
			ST_FADE: state_d = fade_end ? ST_EMIT : ST_MSTART;
			ST_MSTART: state_d = ST_MWAIT;
			ST_MWAIT: begin
				if (mix_done) state_d = (ch_q == CH_BLUE) ? ST_EMIT : ST_MSTART;
			end
			ST_EMIT: begin
				if (out_free) state_d = emit_last_q ? ST_IDLE : adv_state;
			end
			ST_STAT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		mix_start = (state_q == ST_MSTART);
		out_load  = ((state_q == ST_EMIT) || (state_q == ST_STAT)) && out_free;
		adv       = ((state_q == ST_SCAN) && !armed_q[idx_q]) ||
		            ((state_q == ST_HOLD) && in_hold) ||
		            ((state_q == ST_EMIT) && out_free && !emit_last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			ch_q        <= CH_RED;
			force_q     <= 1'b0;
			any_q       <= 1'b0;
			emit_last_q <= 1'b0;
			now_q       <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				armed_q[i] <= 1'b0;
				shown_q[i] <= 24'd0;
			end
		end else begin
			state_q <= state_d;
			if (adv) idx_q <= idx_q + SLOT_W'(1);
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						force_q     <= (s_tuser == OP_FORCE);
						any_q       <= 1'b0;
						emit_last_q <= (s_tuser == OP_SET);
						idx_q       <= (s_tuser == OP_SET) ? SLOT_W'(s_tdata[3:0]) : '0;
						if (s_tuser == OP_TICK) now_q <= now_q + TIME_BITS'(1);
					end
				end
				ST_SET: begin
					if (slot_ok_q) begin
						if (timed) armed_q[idx_q] <= 1'b1;
						else armed_q[idx_q] <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (armed_q[idx_q]) begin
						any_q <= 1'b1;
						if (force_q) armed_q[idx_q] <= 1'b0;
					end
				end
				ST_FADE: begin
					ch_q <= CH_RED;
					if (fade_end) armed_q[idx_q] <= 1'b0;
				end
				ST_MWAIT: if (mix_done) ch_q <= ch_q + 2'd1;
				ST_EMIT: if (out_free) shown_q[idx_q] <= col_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				slot_ok_q <= 32'(s_tdata[3:0]) < SLOTS;
				in_col_q  <= {s_tdata[11:4], s_tdata[19:12], s_tdata[27:20]};
				in_hold_q <= s_tdata[43:28];
				in_fade_q <= s_tdata[59:44];
			end
			ST_SET: begin
				col_q <= in_col_q;
				if (slot_ok_q && timed &&
				    (!armed_q[idx_q] || (target_q[idx_q] != in_col_q))) begin
					start_q[idx_q]  <= shown_q[idx_q];
					target_q[idx_q] <= in_col_q;
					arm_q[idx_q]    <= now_q;
					hold_q[idx_q]   <= in_hold_q;
					fade_q[idx_q]   <= in_fade_q;
				end
			end
			ST_SCAN: begin
				col_q <= target_q[idx_q];
				e_q   <= now_q - arm_q[idx_q];
			end
			ST_HOLD: t_q <= e_q - TIME_BITS'(hold_q[idx_q]);
			ST_MWAIT: begin
				if (mix_done) begin
					case (ch_q)
						CH_RED:   col_q[23:16] <= mix_res;
						CH_GREEN: col_q[15:8]  <= mix_res;
						default:  col_q[7:0]   <= mix_res;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_STAT) begin
				m_tdata_q <= {3'd0, any_q, 28'd0};
				m_tuser_q <= KIND_STATUS;
				m_tlast_q <= 1'b1;
			end else begin
				m_tdata_q <= {3'd0, 1'b0, col_q[7:0], col_q[15:8], col_q[23:16], 4'(idx_q)};
				m_tuser_q <= KIND_COLOR;
				m_tlast_q <= emit_last_q;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

>>> rtl/core/lfe_checker.sv
// ----------------------------------------------------------------------------
// lfe_checker
// Port-level checks of the fade engine output words.
// ----------------------------------------------------------------------------
`default_nettype none

module lfe_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     m_tvalid,
	input wire logic                     m_tready,
	input wire logic [lfe_pkg::OUT_W-1:0] m_tdata,
	input wire logic                     m_tuser,
	input wire logic                     m_tlast
);
	import lfe_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_STATUS) |-> m_tlast)
		else $error("status word without last");

	a_stat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_STATUS) |-> (m_tdata[27:0] == 28'd0))
		else $error("status word carries slot or color");

	a_color_any: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_COLOR) |-> !m_tdata[28])
		else $error("color word carries active flag");

endmodule

bind led_color_fade_engine lfe_checker u_lfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
